// ===== rtl/mt64_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mt64_pkg - shared definitions for the MT19937-64 generator
// Command codes, algorithm constants, twist and tempering functions, and the
// control/status bundles between the top level and the seed unit.
// ============================================================================
package mt64_pkg;

    // Generator geometry
    localparam int STATE_WORDS = 312;

    // Command codes (carried on s_axis_tuser)
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // Twist constants
    localparam logic [63:0] MT_MATRIX   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] MT_UPPER    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MT_LOWER    = 64'h0000_0000_7FFF_FFFF;

    // Seed recurrence multiplier (6364136223846793005)
    localparam logic [63:0] MT_SEED_MUL = 64'h5851_F42D_4C95_7F2D;

    // Tempering masks
    localparam logic [63:0] TEMPER_B = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_C = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_D = 64'hFFF7_EEE0_0000_0000;

    // Seed unit control and status
    typedef struct packed {
        logic        start;
        logic [63:0] seed;
    } seed_ctrl_t;

    typedef struct packed {
        logic busy;
        logic wr_en;
        logic done;
    } seed_stat_t;

    // New state word from the current word, its successor and the far word
    function automatic logic [63:0] mix_word(input logic [63:0] cur,
                                             input logic [63:0] nxt,
                                             input logic [63:0] far);
        logic [63:0] y;
        logic [63:0] r;
        y = (cur & MT_UPPER) | (nxt & MT_LOWER);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ MT_MATRIX;
        end
        return r;
    endfunction

    function automatic logic [63:0] temper(input logic [63:0] v_in);
        logic [63:0] v;
        v = v_in;
        v = v ^ ((v >> 29) & TEMPER_B);
        v = v ^ ((v << 17) & TEMPER_C);
        v = v ^ ((v << 37) & TEMPER_D);
        v = v ^ (v >> 43);
        return v;
    endfunction

endpackage

// ===== rtl/mt64_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mt64_ram - generic synchronous RAM
// One write port, two read ports, registered read data.
// ============================================================================
module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== rtl/mt64_seeder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mt64_seeder - state initialization engine
// Runs w[i] = MUL * (w[i-1] ^ (w[i-1] >> 62)) + i, one word at a time, each going
// through a partial-product stage (32x32 pieces) and a sum stage that writes the RAM.
// ============================================================================
module mt64_seeder #(
    parameter int STATE_WORDS = mt64_pkg::STATE_WORDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mt64_pkg::seed_ctrl_t           ctrl,
    output mt64_pkg::seed_stat_t           stat,
    output logic [$clog2(STATE_WORDS)-1:0] wr_addr,
    output logic [63:0]                    wr_data
);

    localparam int AW = $clog2(STATE_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);
    localparam logic [31:0] MUL_LO = mt64_pkg::MT_SEED_MUL[31:0];
    localparam logic [31:0] MUL_HI = mt64_pkg::MT_SEED_MUL[63:32];

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } seed_state_t;

    seed_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   p_ll_reg, p_ll_next;
    logic [31:0]   p_lh_reg, p_lh_next;
    logic [31:0]   p_hl_reg, p_hl_next;
    logic [63:0]   sum_word;
    logic [31:0]   cross_sum;

    // partial products of the low 64 bits
    assign p_ll_next = 64'(x_reg[31:0]) * 64'(MUL_LO);
    assign p_lh_next = x_reg[31:0] * MUL_HI;
    assign p_hl_next = x_reg[63:32] * MUL_LO;

    assign cross_sum = p_lh_reg + p_hl_reg;
    assign sum_word  = p_ll_reg + {cross_sum, 32'h0} + 64'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        wr_addr    = idx_reg;
        wr_data    = sum_word;
        stat.wr_en = 1'b0;
        stat.done  = 1'b0;
        stat.busy  = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    stat.wr_en = 1'b1;
                    wr_addr    = '0;
                    wr_data    = ctrl.seed;
                    x_next     = ctrl.seed ^ (ctrl.seed >> 62);
                    idx_next   = AW'(1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                stat.wr_en = 1'b1;
                x_next     = sum_word ^ (sum_word >> 62);
                if (idx_reg == LAST_IDX)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            x_reg     <= '0;
            p_ll_reg  <= '0;
            p_lh_reg  <= '0;
            p_hl_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            x_reg     <= x_next;
            p_ll_reg  <= p_ll_next;
            p_lh_reg  <= p_lh_next;
            p_hl_reg  <= p_hl_next;
        end
    end

endmodule

// ===== rtl/mersenne_twister_64_generator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mersenne_twister_64_generator - MT19937-64 pseudo-random word generator
// Seed and next commands on a stream input, tempered words on a stream output.
// ============================================================================
// Usage: send a seed item (tuser = 0, tdata = seed) and then next items
// (tuser = 1); each next item returns one tempered 64-bit word, the standard
// MT19937-64 sequence for that seed. A seed item produces no output item.
// A next item before any seed returns 0 with the not-seeded flag (m_axis_tuser)
// set. Timing: a seeded next item is accepted in T_IDLE; in T_MIX the RAM read
// data are mixed, written back and tempered, and the result waits in T_RESULT
// while the output register is full. The RAM read data are registered, so the
// mix follows the accept state. A next item before any seed is finished on
// acceptance when the output register is free. A seed item keeps
// s_axis_tready low until the seed unit is done: word 0 is written on acceptance
// and each of the other 311 words passes through the seed unit's partial-product
// step and then its sum-and-write step.
// The twist is done word by word: each next item rewrites one state word, using
// a register copy of the current word and two RAM reads (successor and far word).
// The output register lets a new item be accepted while a result waits.
// ============================================================================
module mersenne_twister_64_generator #(
    parameter int STATE_WORDS = mt64_pkg::STATE_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] random_value
    output logic [0:0]  m_axis_tuser    // [0] not_seeded
);

    localparam int AW         = $clog2(STATE_WORDS);
    localparam int SHIFT_DIST = STATE_WORDS / 2;
    localparam logic [AW-1:0] LAST_POS = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] DIST     = AW'(SHIFT_DIST);

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEED,
        T_MIX,
        T_RESULT
    } top_state_t;

    top_state_t state_reg, state_next;

    // position of the word to twist next, and a copy of its current value
    logic [AW-1:0] pos_reg, pos_next;
    logic [63:0]   cur_reg, cur_next;
    logic          seeded_reg, seeded_next;

    // output register and a hold slot for a result the consumer has not taken
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_data_reg, out_data_next;
    logic          out_flag_reg, out_flag_next;
    logic [63:0]   pend_data_reg, pend_data_next;
    logic          pend_flag_reg, pend_flag_next;

    logic          in_accept;
    logic          out_free;
    logic [AW-1:0] succ_pos;
    logic [AW-1:0] far_pos;
    logic [63:0]   succ_word;
    logic [63:0]   far_word;
    logic [63:0]   new_word;
    logic [63:0]   tempered;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [63:0]   ram_wr_data;

    mt64_pkg::seed_ctrl_t seed_ctrl;
    mt64_pkg::seed_stat_t seed_stat;
    logic [AW-1:0]        seed_wr_addr;
    logic [63:0]          seed_wr_data;

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // successor wraps to word 0, far word sits half the state away
    assign succ_pos = (pos_reg == LAST_POS) ? '0 : pos_reg + AW'(1);
    assign far_pos  = (pos_reg < DIST) ? pos_reg + DIST : pos_reg - DIST;

    assign new_word = mt64_pkg::mix_word(cur_reg, succ_word, far_word);
    assign tempered = mt64_pkg::temper(new_word);

    assign seed_ctrl.start = in_accept && (s_axis_tuser[0] == mt64_pkg::CMD_SEED);
    assign seed_ctrl.seed  = s_axis_tdata;

    // single write port: seed unit, or the twist write-back
    assign ram_wr_en   = seed_stat.wr_en || (state_reg == T_MIX);
    assign ram_wr_addr = (state_reg == T_MIX) ? pos_reg : seed_wr_addr;
    assign ram_wr_data = (state_reg == T_MIX) ? new_word : seed_wr_data;

    mt64_seeder #(
        .STATE_WORDS (STATE_WORDS)
    ) u_seeder (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (seed_ctrl),
        .stat    (seed_stat),
        .wr_addr (seed_wr_addr),
        .wr_data (seed_wr_data)
    );

    // addresses follow pos_reg, which holds still from accept through T_MIX
    mt64_ram #(
        .WIDTH (64),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (succ_pos),
        .rd_addr_b (far_pos),
        .rd_data_a (succ_word),
        .rd_data_b (far_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        seeded_next    = seeded_reg;
        pend_data_next = pend_data_reg;
        pend_flag_next = pend_flag_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser[0] == mt64_pkg::CMD_SEED)
                    begin
                        cur_next   = s_axis_tdata;
                        state_next = T_SEED;
                    end
                    else if (!seeded_reg)
                    begin
                        // next before any seed: zero word, flag set
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_flag_next  = 1'b1;
                        end
                        else
                        begin
                            pend_data_next = '0;
                            pend_flag_next = 1'b1;
                            state_next     = T_RESULT;
                        end
                    end
                    else
                    begin
                        state_next = T_MIX;
                    end
                end
            end
            T_SEED:
            begin
                if (seed_stat.done)
                begin
                    pos_next    = '0;
                    seeded_next = 1'b1;
                    state_next  = T_IDLE;
                end
            end
            T_MIX:
            begin
                cur_next = succ_word;
                pos_next = succ_pos;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = tempered;
                    out_flag_next  = 1'b0;
                    state_next     = T_IDLE;
                end
                else
                begin
                    pend_data_next = tempered;
                    pend_flag_next = 1'b0;
                    state_next     = T_RESULT;
                end
            end
            T_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_data_reg;
                    out_flag_next  = pend_flag_reg;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pos_reg       <= '0;
            cur_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_flag_reg  <= 1'b0;
            pend_data_reg <= '0;
            pend_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_flag_reg  <= out_flag_next;
            pend_data_reg <= pend_data_next;
            pend_flag_reg <= pend_flag_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_flag_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // no item is taken while the seed unit owns the RAM
    a_no_accept_while_seeding: assert property (
        @(posedge clk) disable iff (!rst_n)
        seed_stat.busy |-> !s_axis_tready
    ) else $error("input accepted while seeding");

    // an unseeded result always carries a zero word
    a_unseeded_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 64'h0)
    ) else $error("not-seeded result with nonzero data");

    // twist position stays inside the state
    a_pos_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS
    ) else $error("twist position out of range");

    // finishing a seed restarts the sequence at word 0
    a_seed_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        seed_stat.done |=> (pos_reg == '0) && seeded_reg
    ) else $error("seed did not restart the sequence");

endmodule

// ===== sim/mt64_stream_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mt64_stream_checker - output predictor and comparator for the MT19937-64 block
// Watches both stream channels, keeps its own copy of the generator state,
// queues the expected word for every next item and compares output items.
// ============================================================================
module mt64_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
    input  logic [0:0]  s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // [63:0] random_value
    input  logic [0:0]  m_axis_tuser,   // [0] not_seeded
    output int          failures,
    output int          pending
);

    localparam int          GEN_WORDS  = 312;
    localparam int          GEN_SHIFT  = 156;
    localparam logic [63:0] TWIST_XOR  = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] HIGH_MASK  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOW_MASK   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INIT_MUL   = 64'd6364136223846793005;
    localparam logic [63:0] SHAPE_B    = 64'h5555_5555_5555_5555;
    localparam logic [63:0] SHAPE_C    = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] SHAPE_D    = 64'hFFF7_EEE0_0000_0000;

    typedef struct packed {
        logic [63:0] word;
        logic        unseeded;
    } mt_result_t;

    logic [63:0]  gen_state [GEN_WORDS];
    int unsigned  gen_pos    = GEN_WORDS;
    bit           gen_seeded = 1'b0;
    mt_result_t   expected_words [$];

    function automatic void load_seed(input logic [63:0] seed);
        logic [63:0] prev;
        gen_state[0] = seed;
        for (int k = 1; k < GEN_WORDS; k++)
        begin
            prev = gen_state[k - 1];
            gen_state[k] = INIT_MUL * (prev ^ (prev >> 62)) + 64'(k);
        end
        gen_pos    = GEN_WORDS;
        gen_seeded = 1'b1;
    endfunction

    // in-place batch twist; later words see already updated neighbors
    function automatic void regenerate_state();
        logic [63:0] joined;
        for (int k = 0; k < GEN_WORDS; k++)
        begin
            joined = (gen_state[k] & HIGH_MASK) | (gen_state[(k + 1) % GEN_WORDS] & LOW_MASK);
            gen_state[k] = gen_state[(k + GEN_SHIFT) % GEN_WORDS] ^ (joined >> 1)
                           ^ (joined[0] ? TWIST_XOR : 64'd0);
        end
    endfunction

    function automatic logic [63:0] shape_output(input logic [63:0] raw);
        logic [63:0] v;
        v = raw;
        v = v ^ ((v >> 29) & SHAPE_B);
        v = v ^ ((v << 17) & SHAPE_C);
        v = v ^ ((v << 37) & SHAPE_D);
        v = v ^ (v >> 43);
        return v;
    endfunction

    function automatic mt_result_t draw_result();
        mt_result_t r;
        if (!gen_seeded)
        begin
            r.word     = '0;
            r.unseeded = 1'b1;
            return r;
        end
        if (gen_pos >= GEN_WORDS)
        begin
            regenerate_state();
            gen_pos = 0;
        end
        r.word     = shape_output(gen_state[gen_pos]);
        r.unseeded = 1'b0;
        gen_pos++;
        return r;
    endfunction

    // output side is handled before the input side of the same edge
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        mt_result_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            gen_pos    = GEN_WORDS;
            gen_seeded = 1'b0;
            pending   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output item: random_value %h not_seeded %b",
                           m_axis_tdata, m_axis_tuser[0]);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata !== want.word)
                    begin
                        $error("random_value: expected %h, actual %h",
                               want.word, m_axis_tdata);
                        failures++;
                    end
                    if (m_axis_tuser[0] !== want.unseeded)
                    begin
                        $error("not_seeded: expected %b, actual %b",
                               want.unseeded, m_axis_tuser[0]);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == mt64_pkg::CMD_SEED)
                begin
                    load_seed(s_axis_tdata);
                end
                else
                begin
                    expected_words.push_back(draw_result());
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== sim/mersenne_twister_64_generator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mersenne_twister_64_generator_tb - stream test of the MT19937-64 generator
// Drives seed and next items with random gaps and output back-pressure; the
// checker beside the block predicts every word and counts mismatches.
// ============================================================================
module mersenne_twister_64_generator_tb;

    localparam int CLK_HALF       = 6;     // 12 ns period
    localparam int RESET_CYCLES   = 10;
    localparam int LONG_RUN       = 330;   // nexts after one seed, crosses the state wrap
    localparam int HOLD_AT        = 40;    // long-run item where the output hold starts
    localparam int HOLD_BURST     = 20;    // items offered back to back during the hold
    localparam int PAUSE_AT       = 150;   // long-run item where the sender drains the block
    localparam int MIXED_ITEMS    = 70;
    localparam int QUIET_TAIL     = 40;    // last items run with no idling on either side
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 16;
    // must exceed the time a seed keeps the input closed, plus gaps and stalls
    localparam int STALL_LIMIT    = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [63:0] seed_value
    logic [0:0]  s_axis_tuser;     // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // [63:0] random_value
    logic [0:0]  m_axis_tuser;     // [0] not_seeded

    int failures;
    int pending;
    bit rx_hold_req = 1'b0;        // sender asks the receiver for one long hold
    bit quiet_tail  = 1'b0;        // end of run: no idling on either side

    mersenne_twister_64_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mt64_stream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // single reset pulse at the start of the run
    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one item and return at the edge where it is taken.
    // tvalid stays high so that a following item goes out back to back.
    task automatic offer(input logic cmd, input logic [63:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Random idle burst on the input side, skipped in the quiet tail.
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Stop offering until every predicted word has come out.
    // pending is registered in the checker, so look after the next edge.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready pattern, one long hold on request, always
    // ready in the quiet tail. Each branch makes one assignment to m_axis_tready, then waits.
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves on either channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [63:0] seed_list [5];
        int          n;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mt64_pkg::CMD_NEXT;
        seed_list = '{64'd0, '1, 64'd5489, 64'h8000_0000_0000_0000, 64'd1};
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Next before any seed: zero word with the not-seeded flag; the data
        // field is ignored, so give it both extremes.
        offer(mt64_pkg::CMD_NEXT, '1);
        offer(mt64_pkg::CMD_NEXT, '0);

        // Extreme and classic seeds, a few words from each
        foreach (seed_list[i])
        begin
            sender_gap();
            offer(mt64_pkg::CMD_SEED, seed_list[i]);
            repeat (3)
            begin
                sender_gap();
                offer(mt64_pkg::CMD_NEXT, rand64());
            end
        end

        // Reseed straight after a seed, then draw
        offer(mt64_pkg::CMD_SEED, 64'h0123_4567_89AB_CDEF);
        offer(mt64_pkg::CMD_SEED, rand64());
        offer(mt64_pkg::CMD_NEXT, rand64());

        // Long run from one seed: goes past the end of the state so the
        // word-by-word twist wraps around. Partway through, the receiver holds
        // off while items keep coming, and later the sender drains the block.
        sender_gap();
        offer(mt64_pkg::CMD_SEED, rand64());
        for (n = 0; n < LONG_RUN; n++)
        begin
            if (n == HOLD_AT)
            begin
                rx_hold_req = 1'b1;
            end
            if (n == PAUSE_AT)
            begin
                wait_drained();
            end
            if (n < HOLD_AT || n >= HOLD_AT + HOLD_BURST)
            begin
                sender_gap();
            end
            offer(mt64_pkg::CMD_NEXT, rand64());
        end

        // Mixed traffic with occasional reseeds; the tail runs flat out
        for (n = 0; n < MIXED_ITEMS; n++)
        begin
            if (n == MIXED_ITEMS - QUIET_TAIL)
            begin
                quiet_tail = 1'b1;
            end
            sender_gap();
            if ($urandom_range(0, 9) == 0)
            begin
                offer(mt64_pkg::CMD_SEED, rand64());
            end
            else
            begin
                offer(mt64_pkg::CMD_NEXT, rand64());
            end
        end

        // Let every predicted word arrive, then watch for stray output items
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mt64_pkg.sv
rtl/mt64_ram.sv
rtl/mt64_seeder.sv
rtl/mersenne_twister_64_generator.sv
sim/mt64_stream_checker.sv
sim/mersenne_twister_64_generator_tb.sv
